/* src/ddfd_pkg.sv */
// ----------------------------------------------------------------------------
// Frame detector package
// Shared widths, register indexes, frame modes and channel payload types.
// ----------------------------------------------------------------------------
package ddfd_pkg;

   localparam int STAMP_W  = 48;
   localparam int TICK_W   = 47;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 32;
   localparam int SUM_W    = 48;
   localparam int PROD_W   = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [63:0] LIMIT_RESET_UNITS = 64'd1000;

   localparam logic [1:0] FRAME_MODE_THRESHOLD = 2'd0;
   localparam logic [1:0] FRAME_MODE_DELTA     = 2'd1;
   localparam logic [1:0] FRAME_MODE_AGGREGATE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REPORT_ON_UPDATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AGGREGATE_KIND   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_THRESHOLD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DELTA_LIMIT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AGGREGATE_LIMIT  = 3'd5;

   localparam logic AGGREGATE_KIND_SUM = 1'b1;

   typedef struct packed {
      logic [1:0]                frame_mode;
      logic                      report_on_update;
      logic                      aggregate_kind;
      logic signed [VALUE_W-1:0] level_threshold;
      logic [VALUE_W-2:0]        delta_limit;
      logic signed [VALUE_W-1:0] aggregate_limit;
   } cfg_type;

   typedef struct packed {
      logic                      load;
      logic signed [VALUE_W-1:0] value;
   } limit_load_type;

   typedef struct packed {
      logic               did_close;
      logic               did_update;
      logic               did_open;
      logic               report_valid;
      logic [TICK_W-1:0]  report_start;
      logic [TICK_W-1:0]  report_end;
      logic [COUNT_W-1:0] report_size;
   } result_type;

endpackage

/* src/ddfd_if.sv */
// ----------------------------------------------------------------------------
// Frame detector channel interfaces
// Tuple request, frame result and register write channels.
// ----------------------------------------------------------------------------
interface ddfd_req_if;
   import ddfd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [STAMP_W-1:0] stamp;
   logic signed [VALUE_W-1:0] sample_value;

   modport source (output valid, output stamp, output sample_value, input ready);
   modport sink   (input valid, input stamp, input sample_value, output ready);
endinterface

interface ddfd_rsp_if;
   import ddfd_pkg::*;

   logic               valid;
   logic               ready;
   logic               did_close;
   logic               did_update;
   logic               did_open;
   logic               report_valid;
   logic [TICK_W-1:0]  report_start;
   logic [TICK_W-1:0]  report_end;
   logic [COUNT_W-1:0] report_size;

   modport source (output valid, output did_close, output did_update, output did_open,
                   output report_valid, output report_start, output report_end,
                   output report_size, input ready);
   modport sink   (input valid, input did_close, input did_update, input did_open,
                   input report_valid, input report_start, input report_end,
                   input report_size, output ready);
   modport monitor (input valid, input ready, input did_close, input did_update,
                    input did_open, input report_valid, input report_start,
                    input report_end, input report_size);
endinterface

interface ddfd_csr_if;
   import ddfd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/ddfd_csr.sv */
// ----------------------------------------------------------------------------
// Frame detector configuration registers
// Holds the six control registers and flags writes of the aggregate limit.
// ----------------------------------------------------------------------------
module ddfd_csr #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            write,
   input  logic [ddfd_pkg::CSR_IDX_W-1:0]  index,
   input  logic [ddfd_pkg::CSR_DATA_W-1:0] data,
   output ddfd_pkg::cfg_type               cfg,
   output ddfd_pkg::limit_load_type        limit_load
);
   import ddfd_pkg::*;

   localparam logic [63:0] ONE_Q       = 64'd1 << FRAC_BITS;
   localparam logic [63:0] LIMIT_RESET = LIMIT_RESET_UNITS * ONE_Q;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            REG_FRAME_MODE:       cfg_in.frame_mode       = data[1:0];
            REG_REPORT_ON_UPDATE: cfg_in.report_on_update = data[0];
            REG_AGGREGATE_KIND:   cfg_in.aggregate_kind   = data[0];
            REG_LEVEL_THRESHOLD:  cfg_in.level_threshold  = $signed(data);
            REG_DELTA_LIMIT:      cfg_in.delta_limit      = data[VALUE_W-2:0];
            REG_AGGREGATE_LIMIT:  cfg_in.aggregate_limit  = $signed(data);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_mode       <= FRAME_MODE_THRESHOLD;
         cfg_ff.report_on_update <= 1'b0;
         cfg_ff.aggregate_kind   <= AGGREGATE_KIND_SUM;
         cfg_ff.level_threshold  <= $signed(LIMIT_RESET[VALUE_W-1:0]);
         cfg_ff.delta_limit      <= LIMIT_RESET[VALUE_W-2:0];
         cfg_ff.aggregate_limit  <= $signed(LIMIT_RESET[VALUE_W-1:0]);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg              = cfg_ff;
   assign limit_load.load  = write && (index == REG_AGGREGATE_LIMIT);
   assign limit_load.value = $signed(data);
endmodule

/* src/ddfd_core.sv */
// ----------------------------------------------------------------------------
// Frame detector decision core
// Frame state and the close, update and open decisions for one tuple.
// ----------------------------------------------------------------------------
module ddfd_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ddfd_pkg::cfg_type                   cfg,
   input  ddfd_pkg::limit_load_type            limit_load,
   input  logic                                step,
   input  logic signed [ddfd_pkg::STAMP_W-1:0] stamp,
   input  logic signed [ddfd_pkg::VALUE_W-1:0] sample_value,
   output ddfd_pkg::result_type                result
);
   import ddfd_pkg::*;

   localparam logic [63:0] ONE_Q     = 64'd1 << FRAC_BITS;
   localparam logic [63:0] MINUS_ONE = 64'd0 - ONE_Q;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic                       active_ff, active_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [VALUE_W-1:0]  ref_ff, ref_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [TICK_W-1:0]          start_ff, start_in;
   logic [TICK_W-1:0]          last_ff, last_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   logic                       ignore;
   logic [TICK_W-1:0]          tick;
   logic [VALUE_W:0]           diff;
   logic [VALUE_W:0]           abs_diff;
   logic                       below_level;
   logic                       delta_hit;
   logic                       aggregate_hit;
   logic                       close_cond;
   logic                       open_cond;
   logic                       closed;
   logic                       updated;
   logic                       opened;
   logic [COUNT_W-1:0]         count_next;
   logic [SUM_W:0]             sum_wide;
   logic signed [SUM_W-1:0]    sum_sat;
   logic signed [PROD_W-1:0]   limit_wide;
   logic signed [PROD_W:0]     prod_full;

   always_comb begin
      tick        = stamp[TICK_W-1:0];
      ignore      = stamp[STAMP_W-1] || (cfg.frame_mode != FRAME_MODE_THRESHOLD &&
                    cfg.frame_mode != FRAME_MODE_DELTA && cfg.frame_mode != FRAME_MODE_AGGREGATE);
      below_level = sample_value < cfg.level_threshold;
      diff        = {ref_ff[VALUE_W-1], ref_ff} - {sample_value[VALUE_W-1], sample_value};
      abs_diff    = diff[VALUE_W] ? ((VALUE_W+1)'(0) - diff) : diff;
      delta_hit   = abs_diff >= {2'b00, cfg.delta_limit};
      limit_wide  = $signed({{(PROD_W-VALUE_W){cfg.aggregate_limit[VALUE_W-1]}},
                             cfg.aggregate_limit});
      if (cfg.aggregate_kind == AGGREGATE_KIND_SUM) begin
         aggregate_hit = sum_ff >= $signed(limit_wide[SUM_W-1:0]);
      end else begin
         aggregate_hit = $signed({{(PROD_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff}) >= prod_ff;
      end

      unique case (cfg.frame_mode)
         FRAME_MODE_THRESHOLD: close_cond = below_level;
         FRAME_MODE_DELTA:     close_cond = delta_hit;
         FRAME_MODE_AGGREGATE: close_cond = aggregate_hit;
         default:              close_cond = 1'b0;
      endcase
      open_cond = (cfg.frame_mode == FRAME_MODE_THRESHOLD) ? !below_level : 1'b1;

      closed  = !ignore && active_ff && close_cond;
      updated = !ignore && active_ff && !close_cond;
      opened  = !ignore && !updated && open_cond;

      count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      sum_wide   = {sum_ff[SUM_W-1], sum_ff} +
                   {{(SUM_W+1-VALUE_W){sample_value[VALUE_W-1]}}, sample_value};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = $signed(sum_wide[SUM_W-1:0]);
      end
      prod_full = limit_load.value * $signed({1'b0, count_ff});
   end

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      ref_in    = ref_ff;
      sum_in    = sum_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      prod_in   = prod_ff;
      if (step) begin
         if (closed) begin
            active_in = 1'b0;
         end
         if (updated) begin
            count_in = count_next;
            sum_in   = sum_sat;
            last_in  = tick;
            if (count_ff != COUNT_MAX) begin
               prod_in = prod_ff + limit_wide;
            end
         end
         if (opened) begin
            active_in = 1'b1;
            count_in  = {{(COUNT_W-1){1'b0}}, 1'b1};
            sum_in    = $signed({{(SUM_W-VALUE_W){sample_value[VALUE_W-1]}}, sample_value});
            ref_in    = sample_value;
            start_in  = tick;
            last_in   = tick;
            prod_in   = limit_wide;
         end
      end else if (limit_load.load) begin
         prod_in = prod_full[PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
         ref_ff    <= $signed(MINUS_ONE[VALUE_W-1:0]);
         sum_ff    <= '0;
         start_ff  <= '0;
         last_ff   <= '0;
         prod_ff   <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         ref_ff    <= ref_in;
         sum_ff    <= sum_in;
         start_ff  <= start_in;
         last_ff   <= last_in;
         prod_ff   <= prod_in;
      end
   end

   always_comb begin
      result            = '0;
      result.did_close  = closed;
      result.did_update = updated;
      result.did_open   = opened;
      if (cfg.report_on_update) begin
         if (updated) begin
            result.report_valid = 1'b1;
            result.report_start = start_ff;
            result.report_end   = tick;
            result.report_size  = count_next;
         end
      end else if (closed) begin
         result.report_valid = 1'b1;
         result.report_start = start_ff;
         result.report_end   = last_ff;
         result.report_size  = count_ff;
      end
   end
endmodule

/* src/data_driven_frame_detector.sv */
// ----------------------------------------------------------------------------
// Data-driven frame detector
// Splits a stream of (stamp, value) tuples into threshold, delta or
// aggregate frames and returns one result per tuple.
//
//   Channel  Direction  Carries
//   req_bus  in         stamp, sample_value
//   rsp_bus  out        action flags and frame report
//   csr_bus  in         register index and write data
//
// A tuple passes the input register, then the output register; one tuple is
// accepted every cycle unless the result side stalls, and the frame state is
// updated as its result is registered. Reset is synchronous; it restores the
// valid flags, control registers and frame state. A stalled result holds in
// the output register while one more tuple waits in the input register.
// ----------------------------------------------------------------------------
module data_driven_frame_detector #(
   parameter int FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   ddfd_req_if.sink   req_bus,
   ddfd_rsp_if.source rsp_bus,
   ddfd_csr_if.sink   csr_bus
);
   import ddfd_pkg::*;

   logic                      in_valid_ff, in_valid_in;
   logic signed [STAMP_W-1:0] in_stamp_ff;
   logic signed [VALUE_W-1:0] in_value_ff;
   logic                      out_valid_ff, out_valid_in;
   result_type                out_result_ff;
   result_type                core_result;
   cfg_type                   cfg;
   limit_load_type            limit_load;
   logic                      out_free;
   logic                      step;
   logic                      req_take;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   ddfd_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock      (clock),
      .reset      (reset),
      .write      (csr_bus.valid),
      .index      (csr_bus.index),
      .data       (csr_bus.data),
      .cfg        (cfg),
      .limit_load (limit_load)
   );

   ddfd_core #(.FRAC_BITS(FRAC_BITS)) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .limit_load   (limit_load),
      .step         (step),
      .stamp        (in_stamp_ff),
      .sample_value (in_value_ff),
      .result       (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_stamp_ff <= req_bus.stamp;
         in_value_ff <= req_bus.sample_value;
      end
      if (step) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.did_close    = out_result_ff.did_close;
   assign rsp_bus.did_update   = out_result_ff.did_update;
   assign rsp_bus.did_open     = out_result_ff.did_open;
   assign rsp_bus.report_valid = out_result_ff.report_valid;
   assign rsp_bus.report_start = out_result_ff.report_start;
   assign rsp_bus.report_end   = out_result_ff.report_end;
   assign rsp_bus.report_size  = out_result_ff.report_size;
endmodule

/* src/ddfd_checker.sv */
// ----------------------------------------------------------------------------
// Frame detector result checker
// Consistency checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ddfd_checker (
   input logic        clock,
   input logic        reset,
   ddfd_rsp_if.source rsp_bus
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.did_close) &&
      $stable(rsp_bus.did_update) && $stable(rsp_bus.did_open) &&
      $stable(rsp_bus.report_size) && $stable(rsp_bus.report_end))
      else $error("result changed while stalled");

   a_update_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.did_update |-> !rsp_bus.did_close && !rsp_bus.did_open)
      else $error("update reported together with close or open");

   a_quiet_report: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.report_valid |-> rsp_bus.report_start == '0 &&
      rsp_bus.report_end == '0 && rsp_bus.report_size == '0)
      else $error("report fields set without a report");

   a_report_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.report_valid |->
      (rsp_bus.did_close || rsp_bus.did_update) && rsp_bus.report_size != '0)
      else $error("report without a close or update, or of an empty frame");

endmodule

bind data_driven_frame_detector ddfd_checker u_ddfd_checker (
   .clock   (clock),
   .reset   (reset),
   .rsp_bus (rsp_bus)
);

/* tb/ddfd_frame_checker.sv */
// ----------------------------------------------------------------------------
// Frame detector result checker
// Watches the tuple, result and register channels of the frame detector.
// Every accepted tuple is run through an internal frame model that keeps
// its own copy of the registers and the frame state. The predicted result
// is queued and compared field by field with the next accepted result.
// ----------------------------------------------------------------------------
module ddfd_frame_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   ddfd_req_if          req_bus,
   ddfd_rsp_if.monitor  rsp_bus,
   ddfd_csr_if          csr_bus,
   output int           failures,
   output int           pending,
   output int           checked
);
   import ddfd_pkg::*;

   localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_MIN = -SUM_MAX - 1;

   logic [1:0]                cfg_mode;
   logic                      cfg_on_update;
   logic                      cfg_kind;
   logic signed [VALUE_W-1:0] cfg_level;
   logic [VALUE_W-2:0]        cfg_delta;
   logic signed [VALUE_W-1:0] cfg_agg_limit;

   logic                      frm_active;
   logic [COUNT_W-1:0]        frm_count;
   logic signed [VALUE_W-1:0] frm_first;
   logic signed [SUM_W-1:0]   frm_sum;
   logic [TICK_W-1:0]         frm_start;
   logic [TICK_W-1:0]         frm_last;

   result_type frame_results_due[$];

   initial begin
      failures = 0;
      pending  = 0;
      checked  = 0;
   end

   task automatic report_mismatch(string msg);
      $display("[%0t] frame check error: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   function automatic logic aggregate_reached();
      longint level;
      level = longint'(cfg_agg_limit);
      if (cfg_kind == AGGREGATE_KIND_SUM) begin
         return longint'(frm_sum) >= level;
      end
      return longint'(frm_sum) >= level * longint'({32'd0, frm_count});
   endfunction

   function automatic result_type predict_frame(logic signed [STAMP_W-1:0] stamp,
                                                logic signed [VALUE_W-1:0] value);
      result_type res;
      longint     v;
      longint     diff;
      longint     acc;
      logic [TICK_W-1:0] tick;
      logic       hit;

      res = '0;
      if (stamp < 0) begin
         return res;
      end
      if (cfg_mode != FRAME_MODE_THRESHOLD && cfg_mode != FRAME_MODE_DELTA &&
          cfg_mode != FRAME_MODE_AGGREGATE) begin
         return res;
      end
      tick = stamp[TICK_W-1:0];
      v    = longint'(value);
      diff = longint'(frm_first) - v;
      if (diff < 0) begin
         diff = -diff;
      end

      case (cfg_mode)
         FRAME_MODE_THRESHOLD: hit = v < longint'(cfg_level);
         FRAME_MODE_DELTA:     hit = diff >= longint'({33'd0, cfg_delta});
         default:              hit = aggregate_reached();
      endcase
      if (frm_active && hit) begin
         res.did_close = 1'b1;
         frm_active    = 1'b0;
         if (!cfg_on_update) begin
            res.report_start = frm_start;
            res.report_end   = frm_last;
            res.report_size  = frm_count;
         end
      end

      case (cfg_mode)
         FRAME_MODE_THRESHOLD: hit = v >= longint'(cfg_level);
         FRAME_MODE_DELTA:     hit = diff < longint'({33'd0, cfg_delta});
         default:              hit = !aggregate_reached();
      endcase
      if (frm_active && hit) begin
         res.did_update = 1'b1;
         if (frm_count != '1) begin
            frm_count++;
         end
         acc = longint'(frm_sum) + v;
         if (acc > SUM_MAX) begin
            acc = SUM_MAX;
         end
         if (acc < SUM_MIN) begin
            acc = SUM_MIN;
         end
         frm_sum  = SUM_W'(acc);
         frm_last = tick;
         if (cfg_on_update) begin
            res.report_start = frm_start;
            res.report_end   = tick;
            res.report_size  = frm_count;
         end
      end

      hit = (cfg_mode == FRAME_MODE_THRESHOLD) ? (v >= longint'(cfg_level)) : 1'b1;
      if (!frm_active && hit) begin
         res.did_open = 1'b1;
         frm_active   = 1'b1;
         frm_count    = 1;
         frm_sum      = SUM_W'(v);
         frm_first    = value;
         frm_start    = tick;
         frm_last     = tick;
      end

      res.report_valid = cfg_on_update ? res.did_update : res.did_close;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;

      if (reset) begin
         cfg_mode      = FRAME_MODE_THRESHOLD;
         cfg_on_update = 1'b0;
         cfg_kind      = AGGREGATE_KIND_SUM;
         cfg_level     = VALUE_W'(LIMIT_RESET_UNITS << FRAC_BITS);
         cfg_delta     = (VALUE_W - 1)'(LIMIT_RESET_UNITS << FRAC_BITS);
         cfg_agg_limit = VALUE_W'(LIMIT_RESET_UNITS << FRAC_BITS);
         frm_active    = 1'b0;
         frm_count     = '0;
         frm_first     = VALUE_W'(-(longint'(1) <<< FRAC_BITS));
         frm_sum       = '0;
         frm_start     = '0;
         frm_last      = '0;
         frame_results_due.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.did_close    = rsp_bus.did_close;
            got.did_update   = rsp_bus.did_update;
            got.did_open     = rsp_bus.did_open;
            got.report_valid = rsp_bus.report_valid;
            got.report_start = rsp_bus.report_start;
            got.report_end   = rsp_bus.report_end;
            got.report_size  = rsp_bus.report_size;
            if (frame_results_due.size() == 0) begin
               report_mismatch("result transaction arrived with no tuple outstanding");
            end else begin
               want = frame_results_due.pop_front();
               checked++;
               check_field("did_close", got.did_close, want.did_close);
               check_field("did_update", got.did_update, want.did_update);
               check_field("did_open", got.did_open, want.did_open);
               check_field("report_valid", got.report_valid, want.report_valid);
               check_field("report_start", got.report_start, want.report_start);
               check_field("report_end", got.report_end, want.report_end);
               check_field("report_size", got.report_size, want.report_size);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_FRAME_MODE:       cfg_mode      = csr_bus.data[1:0];
               REG_REPORT_ON_UPDATE: cfg_on_update = csr_bus.data[0];
               REG_AGGREGATE_KIND:   cfg_kind      = csr_bus.data[0];
               REG_LEVEL_THRESHOLD:  cfg_level     = csr_bus.data[VALUE_W-1:0];
               REG_DELTA_LIMIT:      cfg_delta     = csr_bus.data[VALUE_W-2:0];
               REG_AGGREGATE_LIMIT:  cfg_agg_limit = csr_bus.data[VALUE_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            frame_results_due.push_back(predict_frame(req_bus.stamp, req_bus.sample_value));
         end
      end
      pending = frame_results_due.size();
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Frame detector testbench
// Drives tuples and register writes into the data-driven frame detector and
// leaves all result checking to the frame checker beside it. A short directed
// part covers field extremes, ignored tuples, an unused register index and
// each framing scheme; random phases then sweep the register settings with
// tuples shaped around the active level or limit, under random idle gaps,
// a long result stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
   import ddfd_pkg::*;

   localparam int     CLOCK_PERIOD   = 12;
   localparam int     FRAC           = 16;
   localparam longint TIMEOUT_CYCLES = 2000000;
   localparam longint Q_ONE          = longint'(1) << FRAC;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN     = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] LIMIT_RESET   = 32'sd65536000;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED        = 3'd7;
   localparam logic [1:0]           FRAME_MODE_UNUSED = 2'd3;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   checked;

   int     rsp_hold_request;
   bit     calm;
   longint stamp_clock;
   longint delta_center;
   int     tuples_sent;

   logic [1:0] cur_mode;
   logic       cur_kind;
   longint     cur_level;
   longint     cur_delta;
   longint     cur_agg;

   ddfd_req_if req_bus ();
   ddfd_rsp_if rsp_bus ();
   ddfd_csr_if csr_bus ();

   data_driven_frame_detector #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   ddfd_frame_checker #(
      .FRAC_BITS(FRAC)
   ) frame_check (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .failures(failures),
      .pending (pending),
      .checked (checked)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(longint'(CLOCK_PERIOD) * TIMEOUT_CYCLES);
      $display("Timeout with %0d results still outstanding.", pending);
      $display("Verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return 0;
      end
      if (pick < 88) begin
         return $urandom_range(1, 3);
      end
      if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(15, 30);
   endfunction

   function automatic logic signed [VALUE_W-1:0] to_value(longint x);
      if (x > longint'(VALUE_MAX)) begin
         return VALUE_MAX;
      end
      if (x < longint'(VALUE_MIN)) begin
         return VALUE_MIN;
      end
      return VALUE_W'(x);
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      int unsigned pick;
      longint      center;
      longint      spread;
      longint      offset;

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         return $urandom;
      end
      if (pick < 12) begin
         case ($urandom_range(0, 3))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            default: return '1;
         endcase
      end
      if (cur_mode == FRAME_MODE_DELTA) begin
         if (pick < 16) begin
            delta_center = longint'($signed($urandom)) >>> 2;
         end
         center = delta_center;
         spread = cur_delta + cur_delta / 2 + Q_ONE;
      end else if (cur_mode == FRAME_MODE_AGGREGATE) begin
         center = (cur_kind == AGGREGATE_KIND_SUM) ? cur_agg / 4 : cur_agg;
         spread = ((center < 0) ? -center : center) / 2 + Q_ONE;
      end else begin
         center = cur_level;
         spread = 3 * Q_ONE;
      end
      offset = longint'($urandom_range(0, 32'(spread)));
      if ($urandom_range(0, 1)) begin
         offset = -offset;
      end
      return to_value(center + offset);
   endfunction

   function automatic logic signed [STAMP_W-1:0] next_stamp();
      logic [63:0] wide;
      int unsigned pick;

      wide = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         wide[STAMP_W-1] = 1'b1;
         return wide[STAMP_W-1:0];
      end
      if (pick < 7) begin
         wide[STAMP_W-1] = 1'b0;
         return wide[STAMP_W-1:0];
      end
      stamp_clock += $urandom_range(1, 50);
      return STAMP_W'(stamp_clock);
   endfunction

   task automatic send_tuple(logic signed [STAMP_W-1:0] stamp,
                             logic signed [VALUE_W-1:0] value);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.stamp        <= stamp;
      req_bus.sample_value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      tuples_sent++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [1:0] mode, logic on_update, logic kind,
                            logic signed [VALUE_W-1:0] level,
                            logic [CSR_DATA_W-1:0] delta_word,
                            logic signed [VALUE_W-1:0] agg);
      wait_idle();
      csr_write(REG_FRAME_MODE, CSR_DATA_W'(mode));
      csr_write(REG_REPORT_ON_UPDATE, CSR_DATA_W'(on_update));
      csr_write(REG_AGGREGATE_KIND, CSR_DATA_W'(kind));
      csr_write(REG_LEVEL_THRESHOLD, level);
      csr_write(REG_DELTA_LIMIT, delta_word);
      csr_write(REG_AGGREGATE_LIMIT, agg);
      cur_mode  = mode;
      cur_kind  = kind;
      cur_level = longint'(level);
      cur_delta = longint'({33'd0, delta_word[VALUE_W-2:0]});
      cur_agg   = longint'(agg);
   endtask

   task automatic run_items(int count, bit pressure);
      for (int k = 0; k < count; k++) begin
         if (k % 32 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         if (pressure && k == count / 3) begin
            rsp_hold_request = 80;
            calm = 1'b1;
         end
         if (pressure && k == (2 * count) / 3) begin
            wait_idle();
         end
         send_tuple(next_stamp(), random_value());
      end
      calm = 1'b0;
   endtask

   // Result side: random stalls, a forced long hold-off on request, and
   // always-ready stretches while the stimulus runs calm.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            rsp_bus.ready <= (stall_left == 0);
            if (stall_left > 0) begin
               stall_left--;
            end
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.stamp        = '0;
      req_bus.sample_value = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      rsp_hold_request     = 0;
      calm                 = 1'b0;
      stamp_clock          = 100;
      delta_center         = 0;
      tuples_sent          = 0;
      cur_mode             = FRAME_MODE_THRESHOLD;
      cur_kind             = AGGREGATE_KIND_SUM;
      cur_level            = longint'(LIMIT_RESET);
      cur_delta            = longint'(LIMIT_RESET);
      cur_agg              = longint'(LIMIT_RESET);
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Threshold framing at the reset settings, with stamp extremes.
      send_tuple(-48'sd1, VALUE_MAX);
      send_tuple(48'sd10, LIMIT_RESET);
      send_tuple(48'sd11, VALUE_MAX);
      send_tuple(48'sd12, LIMIT_RESET - 32'sd1);
      send_tuple(48'sd13, VALUE_MIN);
      send_tuple(48'sh7FFF_FFFF_FFFF, LIMIT_RESET);
      send_tuple(48'sh8000_0000_0000, '0);
      send_tuple(48'sd14, '0);

      // Unused register index, the unused mode, and a mode write with
      // upper bits set that must keep only its low bits.
      wait_idle();
      csr_write(REG_UNUSED, '1);
      csr_write(REG_FRAME_MODE, CSR_DATA_W'(FRAME_MODE_UNUSED));
      cur_mode = FRAME_MODE_UNUSED;
      send_tuple(48'sd20, LIMIT_RESET);
      send_tuple(48'sd21, VALUE_MAX);
      wait_idle();
      csr_write(REG_FRAME_MODE, 32'hFFFF_FFFC | CSR_DATA_W'(FRAME_MODE_AGGREGATE));
      cur_mode = FRAME_MODE_AGGREGATE;
      send_tuple(48'sd22, to_value(10 * Q_ONE));
      run_items(100, 1'b0);

      configure(FRAME_MODE_THRESHOLD, 1'b0, AGGREGATE_KIND_SUM, LIMIT_RESET,
                LIMIT_RESET, LIMIT_RESET);
      run_items(150, 1'b1);
      configure(FRAME_MODE_THRESHOLD, 1'b1, AGGREGATE_KIND_SUM,
                to_value(-7 * Q_ONE), 32'd0, VALUE_MAX);
      run_items(150, 1'b0);
      configure(FRAME_MODE_THRESHOLD, 1'b0, ~AGGREGATE_KIND_SUM, VALUE_MIN,
                32'hFFFF_FFFF, VALUE_MIN);
      run_items(60, 1'b0);
      configure(FRAME_MODE_THRESHOLD, 1'b1, AGGREGATE_KIND_SUM, VALUE_MAX,
                LIMIT_RESET, LIMIT_RESET);
      run_items(60, 1'b0);

      // Delta framing: a change of exactly the limit closes and reopens.
      configure(FRAME_MODE_DELTA, 1'b0, AGGREGATE_KIND_SUM, LIMIT_RESET,
                32'(5 * Q_ONE), LIMIT_RESET);
      send_tuple(48'sd200, VALUE_MIN);
      send_tuple(48'sd201, VALUE_MAX);
      send_tuple(48'sd202, to_value(longint'(VALUE_MAX) - 5 * Q_ONE + 1));
      send_tuple(48'sd203, to_value(longint'(VALUE_MAX) - 5 * Q_ONE));
      run_items(150, 1'b1);
      configure(FRAME_MODE_DELTA, 1'b1, AGGREGATE_KIND_SUM, LIMIT_RESET, 32'd0,
                LIMIT_RESET);
      run_items(60, 1'b0);
      configure(FRAME_MODE_DELTA, 1'b0, ~AGGREGATE_KIND_SUM, LIMIT_RESET,
                32'hFFFF_FFFF, LIMIT_RESET);
      run_items(60, 1'b0);

      // Aggregate framing: the test sees the frame before the current tuple.
      configure(FRAME_MODE_AGGREGATE, 1'b0, AGGREGATE_KIND_SUM, LIMIT_RESET,
                LIMIT_RESET, to_value(20 * Q_ONE));
      send_tuple(48'sd300, to_value(10 * Q_ONE));
      send_tuple(48'sd301, to_value(10 * Q_ONE));
      send_tuple(48'sd302, to_value(Q_ONE));
      run_items(150, 1'b0);
      configure(FRAME_MODE_AGGREGATE, 1'b1, ~AGGREGATE_KIND_SUM, LIMIT_RESET,
                LIMIT_RESET, to_value(3 * Q_ONE));
      run_items(150, 1'b1);
      configure(FRAME_MODE_AGGREGATE, 1'b0, ~AGGREGATE_KIND_SUM, LIMIT_RESET,
                LIMIT_RESET, VALUE_MIN);
      run_items(60, 1'b0);
      configure(FRAME_MODE_AGGREGATE, 1'b0, ~AGGREGATE_KIND_SUM, LIMIT_RESET,
                LIMIT_RESET, VALUE_MAX);
      run_items(60, 1'b0);
      configure(FRAME_MODE_AGGREGATE, 1'b1, AGGREGATE_KIND_SUM, LIMIT_RESET,
                LIMIT_RESET, to_value(-5 * Q_ONE));
      run_items(100, 1'b0);

      for (int k = 0; k < 4; k++) begin
         configure(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
         run_items(80, k == 1);
      end

      wait_idle();
      repeat (8) @(negedge clock);
      $display("Run covered %0d tuples over threshold, delta and aggregate frames,",
               tuples_sent);
      $display("both report policies, ignored tuples, result stalls and drain pauses;");
      $display("%0d results were compared, %0d mismatches found.", checked, failures);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/ddfd_pkg.sv
src/ddfd_if.sv
src/ddfd_csr.sv
src/ddfd_core.sv
src/data_driven_frame_detector.sv
src/ddfd_checker.sv
tb/ddfd_frame_checker.sv
tb/tb_top.sv
